### hdl/bfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Widths, command codes, defaults and the request and result types that are
// shared by the interfaces, the allocation engine and the top level.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int BFA_NUM_FRAMES = 4096;
	localparam int BFA_WORD_BITS  = 32;

	localparam int FC_W = 13;
	localparam int PF_W = 12;

	localparam logic [FC_W-1:0] FC_RESET = 13'd4096;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic            cmd;
		logic [PF_W-1:0] page_frame;
		logic            want_writeable;
		logic            want_supervisor;
	} bfa_req_t;

	typedef struct packed {
		logic [PF_W-1:0] frame_out;
		logic            present_out;
		logic            writeable_out;
		logic            supervisor_out;
		logic            changed;
		logic            full_res;
	} bfa_res_t;

endpackage

### hdl/bfa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator channels
// Valid and ready channels for requests, results and the frame count register.
// ----------------------------------------------------------------------------
interface bfa_req_if import bfa_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            cmd;
	logic [PF_W-1:0] page_frame;
	logic            want_writeable;
	logic            want_supervisor;

	modport source (output valid, cmd, page_frame, want_writeable, want_supervisor,
		input ready);
	modport sink (input valid, cmd, page_frame, want_writeable, want_supervisor,
		output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PF_W-1:0] frame_out;
	logic            present_out;
	logic            writeable_out;
	logic            supervisor_out;
	logic            changed;
	logic            full_res;

	modport source (output valid, frame_out, present_out, writeable_out, supervisor_out,
		changed, full_res, input ready);
	modport sink (input valid, frame_out, present_out, writeable_out, supervisor_out,
		changed, full_res, output ready);
endinterface

interface bfa_cfg_if import bfa_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [FC_W-1:0] frame_count;

	modport source (output valid, frame_count, input ready);
	modport sink (input valid, frame_count, output ready);
endinterface

### hdl/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
// An allocate scans the bitmap memory one word per cycle, over at most min(frame_count,
// NUM_FRAMES)/WORD_BITS words; a free reads one word and then writes it back, and a request
// that leaves the bitmap alone needs no memory access; every result passes the output register.
// One request is in work at a time; the next is taken in the cycle after the result has left
// the engine. After reset a clearing pass writes NUM_FRAMES/WORD_BITS words before the
// first request is taken; frame_count resets to 4096.
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit physical frame allocator with a used-frame bitmap, a frame count
// register and a registered result output.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator import bfa_pkg::*; #(
	parameter int NUM_FRAMES = BFA_NUM_FRAMES,
	parameter int WORD_BITS  = BFA_WORD_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	bfa_req_if.sink   req,
	bfa_rsp_if.source rsp,
	bfa_cfg_if.sink   cfg
);

	logic [FC_W-1:0] frame_count_q;
	logic            eng_idle, eng_done, take, start;
	bfa_req_t        eng_req;
	bfa_res_t        eng_res;
	bfa_res_t        out_q;
	logic            out_valid_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FC_RESET;
		end else if (cfg.valid) begin
			frame_count_q <= cfg.frame_count;
		end
	end

	assign req.ready = eng_idle;
	assign start     = req.valid && eng_idle;

	assign eng_req.cmd             = req.cmd;
	assign eng_req.page_frame      = req.page_frame;
	assign eng_req.want_writeable  = req.want_writeable;
	assign eng_req.want_supervisor = req.want_supervisor;

	bfa_engine #(
		.NUM_FRAMES(NUM_FRAMES),
		.WORD_BITS (WORD_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_count(frame_count_q),
		.start      (start),
		.req        (eng_req),
		.idle       (eng_idle),
		.done       (eng_done),
		.res        (eng_res),
		.take       (take)
	);

	// A finished result moves on whenever the output register is empty or being drained.
	assign take = eng_done && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= eng_res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.frame_out      = out_q.frame_out;
	assign rsp.present_out    = out_q.present_out;
	assign rsp.writeable_out  = out_q.writeable_out;
	assign rsp.supervisor_out = out_q.supervisor_out;
	assign rsp.changed        = out_q.changed;
	assign rsp.full_res       = out_q.full_res;

endmodule

### hdl/bfa_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator engine
// Holds the used-frame bitmap in a memory and runs the clearing pass, the
// first-fit word scan and the read-modify-write updates under one sequencer.
// WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
module bfa_engine import bfa_pkg::*; #(
	parameter int NUM_FRAMES = BFA_NUM_FRAMES,
	parameter int WORD_BITS  = BFA_WORD_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [FC_W-1:0] frame_count,
	input  logic            start,
	input  bfa_req_t        req,
	output logic            idle,
	output logic            done,
	output bfa_res_t        res,
	input  logic            take
);

	localparam int NUM_WORDS = NUM_FRAMES / WORD_BITS;
	localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int WB_LOG    = $clog2(WORD_BITS);
	localparam int FW        = WA + WB_LOG;
	localparam int FXW       = (FW > PF_W) ? FW : PF_W;

	typedef enum logic [5:0] {
		ST_CLEAR    = 6'b000001,
		ST_IDLE     = 6'b000010,
		ST_SCAN     = 6'b000100,
		ST_ALLOC_WR = 6'b001000,
		ST_FREE_WR  = 6'b010000,
		ST_DONE     = 6'b100000
	} state_t;

	state_t               state_q, state_d;
	bfa_req_t             req_q, req_d;
	bfa_res_t             res_q, res_d;
	logic [WA:0]          idx_q, idx_d;
	logic [WA:0]          lim_q, lim_d;
	logic                 chk_valid_q, chk_valid_d;
	logic [WA-1:0]        chk_idx_q, chk_idx_d;
	logic [WORD_BITS-1:0] rdata_q;
	logic [WORD_BITS-1:0] mem [NUM_WORDS];

	logic                 mem_we, mem_re;
	logic [WA-1:0]        mem_wa, mem_ra;
	logic [WORD_BITS-1:0] mem_wd;

	logic [31:0]          fc_words;
	logic [WA:0]          lim_new;
	logic [31:0]          in_word, held_word;
	logic                 in_range;
	logic [WB_LOG-1:0]    zero_pos, free_bit;
	logic [FXW-1:0]       frame_full;
	logic                 issue;

	function automatic logic [WB_LOG-1:0] first_zero(input logic [WORD_BITS-1:0] v);
		logic [WB_LOG-1:0] pos;
		pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!v[b]) begin
				pos = WB_LOG'(b);
			end
		end
		return pos;
	endfunction

	assign fc_words  = 32'(frame_count >> WB_LOG);
	assign lim_new   = (fc_words > 32'(NUM_WORDS)) ? (WA+1)'(NUM_WORDS) : (WA+1)'(fc_words);
	assign in_word   = 32'(req.page_frame) >> WB_LOG;
	assign in_range  = in_word < 32'(NUM_WORDS);
	assign held_word = 32'(req_q.page_frame) >> WB_LOG;
	assign free_bit  = req_q.page_frame[WB_LOG-1:0];
	assign zero_pos  = first_zero(rdata_q);
	assign frame_full = (FXW'(chk_idx_q) << WB_LOG) | FXW'(zero_pos);
	assign issue     = idx_q < lim_q;

	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		res_d       = res_q;
		idx_d       = idx_q;
		lim_d       = lim_q;
		chk_valid_d = chk_valid_q;
		chk_idx_d   = chk_idx_q;
		mem_we      = 1'b0;
		mem_wa      = '0;
		mem_wd      = '0;
		mem_re      = 1'b0;
		mem_ra      = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = idx_q[WA-1:0];
				idx_d  = (WA+1)'(idx_q + 1'b1);
				if (idx_q == (WA+1)'(NUM_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					req_d = req;
					res_d = '0;
					if (req.cmd == CMD_ALLOC) begin
						if (req.page_frame != '0) begin
							res_d.frame_out = req.page_frame;
							state_d = ST_DONE;
						end else begin
							idx_d       = '0;
							lim_d       = lim_new;
							chk_valid_d = 1'b0;
							state_d     = ST_SCAN;
						end
					end else if (req.page_frame != '0 && in_range) begin
						mem_re  = 1'b1;
						mem_ra  = in_word[WA-1:0];
						state_d = ST_FREE_WR;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (chk_valid_q && !(&rdata_q)) begin
					state_d = ST_ALLOC_WR;
				end else if (!chk_valid_q && !issue) begin
					res_d.full_res = 1'b1;
					state_d = ST_DONE;
				end else begin
					mem_re      = issue;
					mem_ra      = idx_q[WA-1:0];
					chk_valid_d = issue;
					chk_idx_d   = idx_q[WA-1:0];
					if (issue) begin
						idx_d = (WA+1)'(idx_q + 1'b1);
					end
				end
			end
			ST_ALLOC_WR: begin
				mem_we = 1'b1;
				mem_wa = chk_idx_q;
				mem_wd = rdata_q | (WORD_BITS'(1) << zero_pos);
				res_d.frame_out      = frame_full[PF_W-1:0];
				res_d.present_out    = 1'b1;
				res_d.writeable_out  = req_q.want_writeable;
				res_d.supervisor_out = req_q.want_supervisor;
				res_d.changed        = 1'b1;
				state_d = ST_DONE;
			end
			ST_FREE_WR: begin
				mem_we = 1'b1;
				mem_wa = held_word[WA-1:0];
				mem_wd = rdata_q & ~(WORD_BITS'(1) << free_bit);
				res_d.changed = rdata_q[free_bit];
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			lim_q       <= '0;
			chk_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			lim_q       <= lim_d;
			chk_valid_q <= chk_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q     <= req_d;
		res_q     <= res_d;
		chk_idx_q <= chk_idx_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign res  = res_q;

endmodule
